// ----- hw/rtl/wri_pkg.sv -----
// shared types, constants and helper functions of the waypoint ramp interpolator
package wri_pkg;

  localparam int MAX_POINTS = 8;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NUM_W      = $clog2(MAX_POINTS + 1);

  localparam int SLOT_W    = 3;
  localparam int MINUTE_W  = 11;
  localparam int IN_PCT_W  = 8;
  localparam int PCT_W     = 7;
  localparam int KELVIN_W  = 14;
  localparam int SECOND_W  = 17;
  localparam int LEVEL_W   = 8;
  localparam int COUNT_W   = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHEDULE_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 11'd1439;
  localparam logic [IN_PCT_W-1:0] PERCENT_MAX = 8'd100;
  localparam logic [KELVIN_W-1:0] KELVIN_MIN  = 14'd2500;
  localparam logic [KELVIN_W-1:0] KELVIN_MAX  = 14'd10000;

  // ceil(2^22 / 100), exact for dividends up to 100 * 255
  localparam logic [15:0] RECIP_100 = 16'd41944;

  typedef struct packed {
    logic                op;
    logic [SLOT_W-1:0]   slot;
    logic [MINUTE_W-1:0] new_minute;
    logic [IN_PCT_W-1:0] new_percent;
    logic [KELVIN_W-1:0] new_kelvin;
    logic [SECOND_W-1:0] second_of_day;
  } in_word_t;

  typedef struct packed {
    logic                active;
    logic [LEVEL_W-1:0]  level_byte;
    logic [KELVIN_W-1:0] kelvin_out;
  } out_word_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [PCT_W-1:0]    percent;
    logic [KELVIN_W-1:0] kelvin;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  // percent to byte: 100 -> 255, else percent * 255 / 100 truncated
  function automatic logic [LEVEL_W-1:0] pct_to_byte(input logic [PCT_W-1:0] pct);
    logic [14:0] scaled;
    logic [30:0] prod;
    scaled = {pct, 8'b0} - 15'(pct);
    prod   = 31'(scaled) * 31'(RECIP_100);
    if (8'(pct) >= PERCENT_MAX) begin
      return 8'hff;
    end
    return prod[29:22];
  endfunction

  // minute of day to second of day, times 60 as two shifts
  function automatic logic [SECOND_W-1:0] min_to_sec(input logic [MINUTE_W-1:0] minute);
    return 17'({minute, 6'b0}) - 17'({minute, 2'b0});
  endfunction

endpackage

// ----- hw/rtl/wri_ram.sv -----
// generic single write port ram with registered read
module wri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/waypoint_ramp_interpolator.sv -----
// top level of the waypoint ramp interpolator: table, segment search, serial multiply and divide
//
// A write word stores one clamped waypoint. An evaluate word gives one result word: from S_IDLE
// to S_PUT when the schedule is off or empty, through S_FIRST when the time lies before the first
// waypoint, through S_FIRST and S_LAST at or after the last, and through S_FIRST, S_LAST, S_SCAN,
// S_MUL, S_DIV and S_FIX inside segment k (1 to point_count - 1); an unsorted table in which no
// segment holds the time gives an inactive word once the search reaches the last entry. The table
// is read one entry per cycle through a single ram port during the segment search; the scaling of
// the segment deltas uses a bit-serial multiply (one bit of the offset each cycle) and a bit-serial
// restoring divide by the segment length. The input stalls while an evaluation is at work; a
// finished result waits in the output register while the next word is accepted, and a new result
// waits for a stalled output register to drain before the input frees up.
module waypoint_ramp_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  wri_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output wri_pkg::out_word_t           out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wri_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wri_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import wri_pkg::*;

  localparam int POS_W = SECOND_W;
  localparam int QUO_W = 13;
  localparam int ACC_W = SECOND_W + QUO_W;
  localparam int STEP_W = $clog2(POS_W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIRST = 8'b0000_0010,
    S_LAST  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIX   = 8'b0100_0000,
    S_PUT   = 8'b1000_0000
  } state_e;

  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                input logic [SECOND_W-1:0] span);
    logic [SECOND_W:0] trial;
    logic [SECOND_W:0] rem;
    logic              ge;
    trial = acc[ACC_W-1:QUO_W-1];
    ge    = trial >= {1'b0, span};
    rem   = ge ? trial - {1'b0, span} : trial;
    return {rem[SECOND_W-1:0], acc[QUO_W-2:0], ge};
  endfunction

  state_e state_q, state_d;

  logic                 on_q;
  logic [COUNT_W-1:0]   count_q;
  logic [NUM_W-1:0]     num;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     rd_addr;
  point_t               rd_point;
  logic [POINT_W-1:0]   ram_rdata;
  point_t               wr_point;
  logic                 wr_en;
  logic                 in_acc;

  point_t               prev_q, prev_d;
  logic [SECOND_W-1:0]  sod_q, sod_d;
  logic [SECOND_W-1:0]  span_q, span_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 neg_l_q, neg_l_d, neg_k_q, neg_k_d;
  logic [LEVEL_W-1:0]   mag_l_q, mag_l_d, base_l_q, base_l_d;
  logic [KELVIN_W-1:0]  mag_k_q, mag_k_d, base_k_q, base_k_d;
  logic [ACC_W-1:0]     acc_l_q, acc_l_d, acc_k_q, acc_k_d;
  logic [STEP_W-1:0]    step_q, step_d;
  out_word_t            res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q;
  logic                 out_load;

  logic [SECOND_W-1:0]  seg_a, seg_b;
  logic [LEVEL_W-1:0]   byte_a, byte_b;
  logic [LEVEL_W:0]     diff_l;
  logic [KELVIN_W:0]    diff_k;

  assign num = (32'(count_q) > MAX_POINTS) ? NUM_W'(MAX_POINTS) : NUM_W'(count_q);
  assign last_idx = IDX_W'(num - NUM_W'(1));

  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // clamped waypoint
  always_comb begin
    wr_point.minute = (in_word_i.new_minute > MINUTE_MAX) ? MINUTE_MAX : in_word_i.new_minute;
    wr_point.percent = (in_word_i.new_percent > PERCENT_MAX) ? PCT_W'(PERCENT_MAX)
                                                             : PCT_W'(in_word_i.new_percent);
    if (in_word_i.new_kelvin < KELVIN_MIN) begin
      wr_point.kelvin = KELVIN_MIN;
    end else if (in_word_i.new_kelvin > KELVIN_MAX) begin
      wr_point.kelvin = KELVIN_MAX;
    end else begin
      wr_point.kelvin = in_word_i.new_kelvin;
    end
  end

  assign wr_en = in_acc && (in_word_i.op == OP_WRITE) && (32'(in_word_i.slot) < MAX_POINTS);

  wri_ram #(
    .WIDTH(POINT_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(IDX_W'(in_word_i.slot)),
    .wdata_i(wr_point),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  assign rd_point = point_t'(ram_rdata);

  // segment terms
  always_comb begin
    seg_a  = min_to_sec(prev_q.minute);
    seg_b  = min_to_sec(rd_point.minute);
    byte_a = pct_to_byte(prev_q.percent);
    byte_b = pct_to_byte(rd_point.percent);
    diff_l = {1'b0, byte_b} - {1'b0, byte_a};
    diff_k = {1'b0, rd_point.kelvin} - {1'b0, prev_q.kelvin};
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    prev_d   = prev_q;
    sod_d    = sod_q;
    span_d   = span_q;
    pos_d    = pos_q;
    neg_l_d  = neg_l_q;
    neg_k_d  = neg_k_q;
    mag_l_d  = mag_l_q;
    mag_k_d  = mag_k_q;
    base_l_d = base_l_q;
    base_k_d = base_k_q;
    acc_l_d  = acc_l_q;
    acc_k_d  = acc_k_q;
    step_d   = step_q;
    res_d    = res_q;
    rd_addr  = '0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_word_i.op == OP_EVAL) begin
          sod_d = in_word_i.second_of_day;
          if (!on_q || num == '0) begin
            res_d   = '0;
            state_d = S_PUT;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        rd_addr = last_idx;
        prev_d  = rd_point;
        if (sod_q < min_to_sec(rd_point.minute)) begin
          res_d   = '0;
          state_d = S_PUT;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        rd_addr = IDX_W'(1);
        if (sod_q >= min_to_sec(rd_point.minute)) begin
          res_d.active     = 1'b1;
          res_d.level_byte = pct_to_byte(rd_point.percent);
          res_d.kelvin_out = rd_point.kelvin;
          state_d          = S_PUT;
        end else begin
          idx_d   = IDX_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = idx_q + IDX_W'(1);
        if (sod_q >= seg_a && sod_q < seg_b) begin
          span_d   = seg_b - seg_a;
          pos_d    = sod_q - seg_a;
          neg_l_d  = diff_l[LEVEL_W];
          mag_l_d  = diff_l[LEVEL_W] ? LEVEL_W'(-diff_l) : diff_l[LEVEL_W-1:0];
          neg_k_d  = diff_k[KELVIN_W];
          mag_k_d  = diff_k[KELVIN_W] ? KELVIN_W'(-diff_k) : diff_k[KELVIN_W-1:0];
          base_l_d = byte_a;
          base_k_d = prev_q.kelvin;
          acc_l_d  = '0;
          acc_k_d  = '0;
          step_d   = '0;
          state_d  = S_MUL;
        end else if (idx_q == last_idx) begin
          res_d   = '0;
          state_d = S_PUT;
        end else begin
          prev_d = rd_point;
          idx_d  = idx_q + IDX_W'(1);
        end
      end
      S_MUL: begin
        acc_l_d = {acc_l_q[ACC_W-2:0], 1'b0} + (pos_q[POS_W-1] ? ACC_W'(mag_l_q) : '0);
        acc_k_d = {acc_k_q[ACC_W-2:0], 1'b0} + (pos_q[POS_W-1] ? ACC_W'(mag_k_q) : '0);
        pos_d   = {pos_q[POS_W-2:0], 1'b0};
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(POS_W - 1)) begin
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        acc_l_d = div_step(acc_l_q, span_q);
        acc_k_d = div_step(acc_k_q, span_q);
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUO_W - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        res_d.active     = 1'b1;
        res_d.level_byte = neg_l_q ? base_l_q - LEVEL_W'(acc_l_q[QUO_W-1:0])
                                   : base_l_q + LEVEL_W'(acc_l_q[QUO_W-1:0]);
        res_d.kelvin_out = neg_k_q ? base_k_q - KELVIN_W'(acc_k_q[QUO_W-1:0])
                                   : base_k_q + KELVIN_W'(acc_k_q[QUO_W-1:0]);
        state_d          = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      on_q        <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SCHEDULE_ON: on_q    <= cfg_data_i[0];
          CFG_POINT_COUNT: count_q <= COUNT_W'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q   <= prev_d;
    sod_q    <= sod_d;
    span_q   <= span_d;
    pos_q    <= pos_d;
    neg_l_q  <= neg_l_d;
    neg_k_q  <= neg_k_d;
    mag_l_q  <= mag_l_d;
    mag_k_q  <= mag_k_d;
    base_l_q <= base_l_d;
    base_k_q <= base_k_d;
    acc_l_q  <= acc_l_d;
    acc_k_q  <= acc_k_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // search never runs past the last valid entry
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= last_idx)
    else $error("segment search beyond last waypoint");

  // an inactive word carries zero fields
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.active |-> out_word_o.level_byte == '0 &&
                                          out_word_o.kelvin_out == '0)
    else $error("inactive word with nonzero fields");

  // an accepted evaluation holds off the next word
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.op == OP_EVAL |=> in_stall_o)
    else $error("input not stalled during evaluation");

  // a write word leaves the sequencer idle
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.op == OP_WRITE |=> state_q == S_IDLE)
    else $error("write word started an evaluation");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the waypoint ramp interpolator: table writes, evaluations, config phases
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wri_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 60;
  localparam int WORD_TARGET   = 540;
  localparam int SECOND_TOP    = 131071;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  waypoint_ramp_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the waypoint table and registers
  int        sched_minute [MAX_POINTS];
  int        sched_pct    [MAX_POINTS];
  int        sched_kelvin [MAX_POINTS];
  bit        sched_on    = 1'b0;
  int        sched_count = 0;
  out_word_t pending_ramps [$];

  int        errors     = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  int        stall_pct  = 0;
  int        stall_timer = 0;
  out_word_t want;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pct_byte(input int pct);
    if (pct >= 100) return 255;
    return (pct * 255) / 100;
  endfunction

  function automatic out_word_t ramp_at(input int sod);
    out_word_t r;
    int n, first, last, i, a, b, span, pos, ab, bb, ka, dk, lvl, kel;
    r = '0;
    n = (sched_count > MAX_POINTS) ? MAX_POINTS : sched_count;
    if (!sched_on || n == 0) return r;
    first = sched_minute[0] * 60;
    last  = sched_minute[n-1] * 60;
    if (sod < first) return r;
    if (sod >= last) begin
      r.active     = 1'b1;
      r.level_byte = LEVEL_W'(pct_byte(sched_pct[n-1]));
      r.kelvin_out = KELVIN_W'(sched_kelvin[n-1]);
      return r;
    end
    for (i = 0; i + 1 < n; i++) begin
      a = sched_minute[i] * 60;
      b = sched_minute[i+1] * 60;
      if (sod >= a && sod < b) begin
        span = b - a;
        pos  = sod - a;
        ab   = pct_byte(sched_pct[i]);
        bb   = pct_byte(sched_pct[i+1]);
        ka   = sched_kelvin[i];
        dk   = sched_kelvin[i+1] - ka;
        lvl  = ab + ((bb - ab) * pos) / span;
        kel  = ka + (dk * pos) / span;
        r.active     = 1'b1;
        r.level_byte = LEVEL_W'(lvl);
        r.kelvin_out = KELVIN_W'(kel);
        return r;
      end
    end
    return r;
  endfunction

  function automatic in_word_t write_word(input int slot, input int minute, input int pct,
                                          input int kel);
    in_word_t w;
    w.op            = OP_WRITE;
    w.slot          = SLOT_W'(slot);
    w.new_minute    = MINUTE_W'(minute);
    w.new_percent   = IN_PCT_W'(pct);
    w.new_kelvin    = KELVIN_W'(kel);
    w.second_of_day = SECOND_W'($urandom_range(0, SECOND_TOP));
    return w;
  endfunction

  function automatic in_word_t eval_word(input int sod);
    in_word_t w;
    w.op            = OP_EVAL;
    w.slot          = SLOT_W'($urandom_range(0, 7));
    w.new_minute    = MINUTE_W'($urandom_range(0, 2047));
    w.new_percent   = IN_PCT_W'($urandom_range(0, 255));
    w.new_kelvin    = KELVIN_W'($urandom_range(0, 16383));
    w.second_of_day = SECOND_W'(sod);
    return w;
  endfunction

  function automatic in_word_t noise_word();
    return write_word($urandom_range(0, 7), $urandom_range(0, 2047), $urandom_range(0, 255),
                      $urandom_range(0, 16383));
  endfunction

  task automatic send_word(input in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (w.op == OP_WRITE) begin
      if (int'(w.slot) < MAX_POINTS) begin
        sched_minute[w.slot] = (w.new_minute > MINUTE_MAX) ? MINUTE_MAX : w.new_minute;
        sched_pct[w.slot]    = (w.new_percent > PERCENT_MAX) ? PERCENT_MAX : w.new_percent;
        sched_kelvin[w.slot] = (w.new_kelvin < KELVIN_MIN) ? KELVIN_MIN :
                               (w.new_kelvin > KELVIN_MAX) ? KELVIN_MAX : w.new_kelvin;
      end
    end else begin
      pending_ramps.push_back(ramp_at(int'(w.second_of_day)));
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_ramps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_schedule(input bit on, input int count);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SCHEDULE_ON;
    cfg_data_i  <= CFG_DATA_W'(on);
    do @(posedge clk_i); while (!cfg_ready_o);
    sched_on    = on;
    cfg_index_i <= CFG_POINT_COUNT;
    cfg_data_i  <= CFG_DATA_W'(count);
    do @(posedge clk_i); while (!cfg_ready_o);
    sched_count = count;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_word(eval_word(0));
    send_word(eval_word(SECOND_TOP));
  endtask

  task automatic test_table_fill();
    send_word(write_word(0, 0, 0, 0));
    send_word(write_word(1, 60, 100, 16383));
    send_word(write_word(2, 120, 255, 2500));
    send_word(write_word(3, 300, 50, 9999));
    send_word(write_word(4, 301, 99, 2501));
    send_word(write_word(5, 700, 1, 6000));
    send_word(write_word(6, 1439, 37, 10000));
    send_word(write_word(7, 2047, 255, 16383));
  endtask

  task automatic test_interpolation();
    set_schedule(1'b1, 8);
    send_word(eval_word(0));
    send_word(eval_word(1800));
    send_word(eval_word(3600));
    send_word(eval_word(5000));
    send_word(eval_word(18030));
    send_word(eval_word(86339));
    send_word(eval_word(86340));
    send_word(eval_word(86399));
  endtask

  task automatic test_count_limits();
    set_schedule(1'b1, 15);
    send_word(eval_word(SECOND_TOP));
    set_schedule(1'b1, 1);
    send_word(eval_word(0));
    set_schedule(1'b1, 0);
    send_word(eval_word(100));
    set_schedule(1'b0, 8);
    send_word(eval_word(5000));
  endtask

  task automatic test_unsorted();
    send_word(write_word(0, 500, 80, 4000));
    set_schedule(1'b1, 3);
    send_word(eval_word(100));
    send_word(eval_word(29999));
    send_word(eval_word(40000));
  endtask

  task automatic test_random_schedules();
    bit on;
    int pick, count, n, m, lo, hi, r;
    while (words_sent < WORD_TARGET) begin
      on   = ($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 15);
      if (pick == 0) count = 0;
      else if (pick == 1) count = $urandom_range(9, 15);
      else count = $urandom_range(1, 8);
      set_schedule(on, count);
      n = (count > MAX_POINTS) ? MAX_POINTS : count;
      if ($urandom_range(0, 3) != 0) begin
        // sorted waypoints with random content
        m = $urandom_range(0, 600);
        for (int s = 0; s < n; s++) begin
          send_word(write_word(s, (m > 1439) ? $urandom_range(1439, 2047) : m,
                               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                                             $urandom_range(0, 100),
                               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) :
                                                             $urandom_range(2500, 10000)));
          m += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 400);
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_word(noise_word());
      end
      if (n == 0) begin
        lo = 0;
        hi = 86399;
      end else begin
        lo = sched_minute[0] * 60 - 120;
        hi = sched_minute[n-1] * 60 + 120;
        if (lo < 0) lo = 0;
      end
      repeat ($urandom_range(8, 16)) begin
        r = $urandom_range(0, 9);
        if (r == 0) send_word(noise_word());
        else if (r == 1) send_word(eval_word($urandom_range(0, SECOND_TOP)));
        else send_word(eval_word($urandom_range(lo, hi)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_table_fill();
    test_interpolation();
    test_count_limits();
    test_unsorted();
    test_random_schedules();
    wait_idle();
    if (errors == 0 && pending_ramps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result checking and receiver stall pattern
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_ramps.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %0d/%0d/%0d", $time,
                 out_word_o.active, out_word_o.level_byte, out_word_o.kelvin_out);
        errors++;
      end else begin
        want = pending_ramps.pop_front();
        if (out_word_o.active !== want.active) begin
          $display("%0t: active expected %0d got %0d", $time, want.active, out_word_o.active);
          errors++;
        end
        if (out_word_o.level_byte !== want.level_byte) begin
          $display("%0t: level_byte expected %0d got %0d", $time, want.level_byte,
                   out_word_o.level_byte);
          errors++;
        end
        if (out_word_o.kelvin_out !== want.kelvin_out) begin
          $display("%0t: kelvin_out expected %0d got %0d", $time, want.kelvin_out,
                   out_word_o.kelvin_out);
          errors++;
        end
      end
    end
    if (stall_timer == 0) begin
      stall_timer = $urandom_range(40, 160);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end else begin
      stall_timer--;
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wri_pkg.sv
hw/rtl/wri_ram.sv
hw/rtl/waypoint_ramp_interpolator.sv
tb/sv/testbench.sv
